// File: sv/cdt_pkg.sv
// Package for the connection demux table: sizes, codes, slot record, state type.
// No dependencies.
package cdt_pkg;

  localparam int CONN_SLOTS = 64;
  localparam int ID_W       = $clog2(CONN_SLOTS);
  localparam int PORT_SLOTS = 4096;
  localparam int CIDX_W     = $clog2(PORT_SLOTS);
  localparam int COUNT_BITS = 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [16:0] RPORT_ANY = 17'h1FFFF;
  localparam logic [15:0] FIRST_RST = 16'd1024;
  localparam logic [15:0] END_RST   = 16'd5000;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_UPDATE = 3'd2,
    OP_REMOVE = 3'd3,
    OP_ALLOC  = 3'd4
  } op_e;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_LISTEN    = 3'd2;
  localparam logic [2:0] ST_CONNECTED = 3'd3;
  localparam logic [2:0] ST_SLOT      = 3'd4;
  localparam logic [2:0] ST_EXHAUSTED = 3'd5;

  localparam logic [0:0] CFG_FIRST = 1'b0;
  localparam logic [0:0] CFG_END   = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_INS_CNT_RD,
    S_INS_CNT_WR,
    S_UPD_RD,
    S_UPD_WR,
    S_RM_RD,
    S_RM_CNT,
    S_RM_CNT_WR,
    S_AL_RD,
    S_AL_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] la;
    logic [31:0] ra;
    logic [15:0] lp;
    logic [16:0] rp;
  } slot_t;

  function automatic logic tracked(input logic [15:0] p, input logic [15:0] first,
                                   input logic [15:0] last_x);
    logic [16:0] off;
    off = {1'b0, p} - {1'b0, first};
    return (first < last_x) && (p >= first) && (p < last_x) && (off < 17'(PORT_SLOTS));
  endfunction

  function automatic logic [CIDX_W-1:0] cidx(input logic [15:0] p, input logic [15:0] first);
    logic [15:0] off;
    off = p - first;
    return off[CIDX_W-1:0];
  endfunction

endpackage

// File: sv/connection_demux_table_with_ports.sv
// Connection demux table top level: slot memory, port use-count memory, sequencer.
// Depends on cdt_pkg.
// Lookup scans all slots; insert scans until an exact match or the last slot (skipped
// if the slot is in use); allocate probes tracked ports in turn, bounded by range.
// One item at a time; the next item is taken while the previous result waits.
// Reset and clear_all sweep the use-count memory with the input stalled.
module connection_demux_table_with_ports import cdt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        operation_i,
  input  logic              clear_all_i,
  input  logic [5:0]        conn_id_i,
  input  logic [31:0]       local_addr_i,
  input  logic [31:0]       remote_addr_i,
  input  logic [15:0]       local_port_i,
  input  logic signed [16:0] remote_port_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [5:0]        found_conn_o,
  output logic [1:0]        match_level_o,
  output logic [15:0]       port_o
);

  state_e state_q, state_d;

  logic [15:0] first_q, end_q;
  logic [CONN_SLOTS-1:0] valid_q, valid_d;
  logic [15:0] last_port_q, last_port_d;
  logic [2:0]  op_q, op_d;
  logic [ID_W-1:0] id_q, id_d;
  slot_t key_q, key_d;
  logic [ID_W-1:0] idx_q, idx_d;
  logic [2:0]  best_lv_q, best_lv_d;
  logic [ID_W-1:0] best_id_q, best_id_d;
  logic [15:0] cur_q, cur_d;
  logic [16:0] probes_q, probes_d;
  logic [CIDX_W-1:0] clr_q, clr_d;
  logic        clr_op_q, clr_op_d;
  logic [2:0]  res_status_q, res_status_d;
  logic [ID_W-1:0] res_id_q, res_id_d;
  logic [1:0]  res_lv_q, res_lv_d;
  logic [15:0] res_port_q, res_port_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_status_q, out_status_d;
  logic [5:0]  out_id_q, out_id_d;
  logic [1:0]  out_lv_q, out_lv_d;
  logic [15:0] out_port_q, out_port_d;

  slot_t slot_mem [CONN_SLOTS];
  slot_t slot_rd_q;
  logic [ID_W-1:0] slot_raddr;
  logic        slot_we;
  logic [ID_W-1:0] slot_waddr;
  slot_t slot_wdata;

  logic [COUNT_BITS-1:0] cnt_mem [PORT_SLOTS];
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [CIDX_W-1:0] cnt_raddr;
  logic        cnt_we;
  logic [CIDX_W-1:0] cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  logic in_acc, out_free, scan_last, slot_v;
  logic [3:0] lv_hit;
  logic [15:0] next_cur;
  logic cur_tracked, lp_tracked, rm_tracked, al_fail;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign scan_last = (idx_q == ID_W'(CONN_SLOTS - 1));
  assign slot_v   = valid_q[idx_q];

  always_comb begin
    lv_hit[0] = (slot_rd_q.la == key_q.la) && (slot_rd_q.ra == key_q.ra) &&
                (slot_rd_q.rp == key_q.rp);
    lv_hit[1] = (slot_rd_q.la == 32'd0) && (slot_rd_q.ra == key_q.ra) &&
                (slot_rd_q.rp == key_q.rp);
    lv_hit[2] = (slot_rd_q.la == key_q.la) && (slot_rd_q.ra == 32'd0) &&
                (slot_rd_q.rp == RPORT_ANY);
    lv_hit[3] = (slot_rd_q.la == 32'd0) && (slot_rd_q.ra == 32'd0) &&
                (slot_rd_q.rp == RPORT_ANY);
    lv_hit = lv_hit & {4{slot_v && (slot_rd_q.lp == key_q.lp)}};
  end

  always_comb begin
    next_cur = cur_q + 16'd1;
    if (next_cur == end_q) begin
      next_cur = first_q;
    end
  end

  assign cur_tracked = tracked(cur_q, first_q, end_q);
  assign lp_tracked  = tracked(key_q.lp, first_q, end_q);
  assign rm_tracked  = tracked(slot_rd_q.lp, first_q, end_q);
  assign al_fail     = (cur_q == last_port_q) || (probes_q == 17'h10000);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == '1) begin
          state_d = clr_op_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (clear_all_i) begin
            state_d = S_CLEAR;
          end else begin
            case (operation_i)
              OP_LOOKUP: state_d = S_SCAN_RD;
              OP_INSERT: state_d = valid_q[conn_id_i] ? S_DONE : S_SCAN_RD;
              OP_UPDATE: state_d = valid_q[conn_id_i] ? S_UPD_RD : S_DONE;
              OP_REMOVE: state_d = valid_q[conn_id_i] ? S_RM_RD : S_DONE;
              OP_ALLOC:  state_d = S_AL_RD;
              default:   state_d = S_DONE;
            endcase
          end
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (op_q == OP_INSERT && lv_hit[0]) begin
          state_d = S_DONE;
        end else if (scan_last) begin
          state_d = (op_q == OP_INSERT && lp_tracked) ? S_INS_CNT_RD : S_DONE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_INS_CNT_RD: state_d = S_INS_CNT_WR;
      S_INS_CNT_WR: state_d = S_DONE;
      S_UPD_RD:     state_d = S_UPD_WR;
      S_UPD_WR:     state_d = S_DONE;
      S_RM_RD:      state_d = S_RM_CNT;
      S_RM_CNT:     state_d = rm_tracked ? S_RM_CNT_WR : S_DONE;
      S_RM_CNT_WR:  state_d = S_DONE;
      S_AL_RD:      state_d = cur_tracked ? S_AL_CHK : S_DONE;
      S_AL_CHK: begin
        if (cnt_rd_q == '0 || al_fail) begin
          state_d = S_DONE;
        end else begin
          state_d = S_AL_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    valid_d      = valid_q;
    last_port_d  = last_port_q;
    op_d         = op_q;
    id_d         = id_q;
    key_d        = key_q;
    idx_d        = idx_q;
    best_lv_d    = best_lv_q;
    best_id_d    = best_id_q;
    cur_d        = cur_q;
    probes_d     = probes_q;
    clr_d        = clr_q;
    clr_op_d     = clr_op_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_lv_d     = res_lv_q;
    res_port_d   = res_port_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_lv_d     = out_lv_q;
    out_port_d   = out_port_q;
    slot_raddr   = idx_q;
    slot_we      = 1'b0;
    slot_waddr   = id_q;
    slot_wdata   = key_q;
    cnt_raddr    = cidx(key_q.lp, first_q);
    cnt_we       = 1'b0;
    cnt_waddr    = clr_q;
    cnt_wdata    = '0;

    unique case (state_q)
      S_CLEAR: begin
        cnt_we = 1'b1;
        clr_d  = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d         = operation_i;
          id_d         = conn_id_i;
          key_d        = '{la: local_addr_i, ra: remote_addr_i, lp: local_port_i,
                           rp: remote_port_i};
          idx_d        = '0;
          best_lv_d    = 3'd4;
          best_id_d    = '0;
          cur_d        = last_port_q + 16'd1;
          if (cur_d == end_q) begin
            cur_d = first_q;
          end
          probes_d     = '0;
          res_status_d = ST_NOT_FOUND;
          res_id_d     = '0;
          res_lv_d     = '0;
          res_port_d   = '0;
          if (clear_all_i) begin
            valid_d      = '0;
            last_port_d  = first_q;
            clr_d        = '0;
            clr_op_d     = 1'b1;
            res_status_d = ST_OK;
          end else begin
            case (operation_i)
              OP_INSERT: if (valid_q[conn_id_i]) res_status_d = ST_SLOT;
              OP_UPDATE, OP_REMOVE: if (!valid_q[conn_id_i]) res_status_d = ST_SLOT;
              default: ;
            endcase
          end
        end
      end
      S_SCAN_RD: ;
      S_SCAN_CMP: begin
        idx_d = idx_q + 1'b1;
        if (op_q == OP_LOOKUP) begin
          for (int l = 3; l >= 0; l--) begin
            if (lv_hit[l] && 3'(l) < best_lv_d) begin
              best_lv_d = 3'(l);
              best_id_d = idx_q;
            end
          end
          if (scan_last && best_lv_d != 3'd4) begin
            res_status_d = ST_OK;
            res_id_d     = best_id_d;
            res_lv_d     = best_lv_d[1:0];
          end
        end else if (lv_hit[0]) begin
          res_status_d = (key_q.ra == 32'd0 && key_q.rp == RPORT_ANY) ? ST_LISTEN
                                                                       : ST_CONNECTED;
        end else if (scan_last) begin
          slot_we          = 1'b1;
          valid_d[id_q]    = 1'b1;
          res_status_d     = ST_OK;
        end
      end
      S_INS_CNT_RD: ;
      S_INS_CNT_WR: begin
        cnt_waddr = cidx(key_q.lp, first_q);
        cnt_wdata = cnt_rd_q + 1'b1;
        cnt_we    = (cnt_rd_q != COUNT_MAX);
      end
      S_UPD_RD: slot_raddr = id_q;
      S_UPD_WR: begin
        slot_we      = 1'b1;
        slot_wdata   = '{la: key_q.la, ra: key_q.ra, lp: slot_rd_q.lp, rp: key_q.rp};
        res_status_d = ST_OK;
      end
      S_RM_RD: slot_raddr = id_q;
      S_RM_CNT: begin
        valid_d[id_q] = 1'b0;
        res_status_d  = ST_OK;
        cnt_raddr     = cidx(slot_rd_q.lp, first_q);
        key_d.lp      = slot_rd_q.lp;
      end
      S_RM_CNT_WR: begin
        cnt_waddr = cidx(key_q.lp, first_q);
        cnt_wdata = cnt_rd_q - 1'b1;
        cnt_we    = (cnt_rd_q != '0);
      end
      S_AL_RD: begin
        cnt_raddr = cidx(cur_q, first_q);
        if (!cur_tracked) begin
          last_port_d  = cur_q;
          res_status_d = ST_OK;
          res_port_d   = cur_q;
        end
      end
      S_AL_CHK: begin
        if (cnt_rd_q == '0) begin
          last_port_d  = cur_q;
          res_status_d = ST_OK;
          res_port_d   = cur_q;
        end else if (al_fail) begin
          res_status_d = ST_EXHAUSTED;
        end else begin
          cur_d    = next_cur;
          probes_d = probes_q + 17'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_id_d     = 6'(res_id_q);
          out_lv_d     = res_lv_q;
          out_port_d   = res_port_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      first_q     <= FIRST_RST;
      end_q       <= END_RST;
      valid_q     <= '0;
      last_port_q <= FIRST_RST;
      clr_q       <= '0;
      clr_op_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      last_port_q <= last_port_d;
      clr_q       <= clr_d;
      clr_op_q    <= clr_op_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FIRST: first_q <= cfg_data_i;
          CFG_END:   end_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    best_lv_q    <= best_lv_d;
    best_id_q    <= best_id_d;
    cur_q        <= cur_d;
    probes_q     <= probes_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_lv_q     <= res_lv_d;
    res_port_q   <= res_port_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_lv_q     <= out_lv_d;
    out_port_q   <= out_port_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_conn_o  = out_id_q;
  assign match_level_o = out_lv_q;
  assign port_o        = out_port_q;

`ifndef NO_ASSERTIONS
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o) else $error("input taken during clear");
  a_port_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (port_o == 16'd0))
    else $error("port reported on failure");
  a_level_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && match_level_o != 2'd0) |-> (status_o == ST_OK))
    else $error("match level reported on failure");
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> out_valid_o) else $error("result lost");
`endif

endmodule

// File: sim/conn_table_checker.sv
// Checker for the connection demux table: mirrors configuration writes, predicts each
// reply from its own copy of the slot table and port use counts, and compares.
// Depends on cdt_pkg.
`timescale 1ns / 100ps
module conn_table_checker import cdt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         operation_i,
  input  logic               clear_all_i,
  input  logic [5:0]         conn_id_i,
  input  logic [31:0]        local_addr_i,
  input  logic [31:0]        remote_addr_i,
  input  logic [15:0]        local_port_i,
  input  logic signed [16:0] remote_port_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         status_i,
  input  logic [5:0]         found_conn_i,
  input  logic [1:0]         match_level_i,
  input  logic [15:0]        port_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  found;
    logic [1:0]  level;
    logic [15:0] port;
  } reply_t;

  reply_t                expected_replies[$];
  logic [15:0]           eph_first, eph_end, last_port;
  logic                  valid_tbl[CONN_SLOTS];
  slot_t                 slot_tbl[CONN_SLOTS];
  logic [COUNT_BITS-1:0] use_count[PORT_SLOTS];

  function automatic logic port_tracked(input logic [15:0] p, output int idx);
    idx = int'(p) - int'(eph_first);
    return (eph_first < eph_end) && (p >= eph_first) && (p < eph_end) && (idx < PORT_SLOTS);
  endfunction

  function automatic logic [15:0] step_port(input logic [15:0] p);
    logic [15:0] n;
    n = p + 16'd1;
    return (n == eph_end) ? eph_first : n;
  endfunction

  function automatic int find_slot(input slot_t key);
    for (int i = 0; i < CONN_SLOTS; i++) begin
      if (valid_tbl[i] && slot_tbl[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic empty_table();
    for (int i = 0; i < CONN_SLOTS; i++) begin
      valid_tbl[i] = 1'b0;
      slot_tbl[i] = '0;
    end
    for (int i = 0; i < PORT_SLOTS; i++) use_count[i] = '0;
    last_port = eph_first;
  endtask

  task automatic predict_table_op(output reply_t r);
    slot_t       key;
    int          hit, idx, id;
    logic [15:0] start, cur;
    key = '{la: local_addr_i, ra: remote_addr_i, lp: local_port_i, rp: remote_port_i};
    id = int'(conn_id_i);
    r = '{status: ST_NOT_FOUND, found: '0, level: '0, port: '0};
    if (clear_all_i) begin
      empty_table();
      r.status = ST_OK;
    end else begin
      case (operation_i)
        OP_LOOKUP: begin
          for (int lv = 0; lv < 4; lv++) begin
            slot_t k;
            k = key;
            if (lv[0]) k.la = '0;
            if (lv[1]) begin
              k.ra = '0;
              k.rp = RPORT_ANY;
            end
            hit = find_slot(k);
            if (hit >= 0) begin
              r.status = ST_OK;
              r.found = hit[5:0];
              r.level = lv[1:0];
              break;
            end
          end
        end
        OP_INSERT: begin
          if (valid_tbl[id]) r.status = ST_SLOT;
          else if (find_slot(key) >= 0)
            r.status = (key.ra == '0 && key.rp == RPORT_ANY) ? ST_LISTEN : ST_CONNECTED;
          else begin
            valid_tbl[id] = 1'b1;
            slot_tbl[id] = key;
            if (port_tracked(key.lp, idx) && use_count[idx] != COUNT_MAX)
              use_count[idx] = use_count[idx] + 1'b1;
            r.status = ST_OK;
          end
        end
        OP_UPDATE: begin
          if (!valid_tbl[id]) r.status = ST_SLOT;
          else begin
            slot_tbl[id].la = key.la;
            slot_tbl[id].ra = key.ra;
            slot_tbl[id].rp = key.rp;
            r.status = ST_OK;
          end
        end
        OP_REMOVE: begin
          if (!valid_tbl[id]) r.status = ST_SLOT;
          else begin
            valid_tbl[id] = 1'b0;
            if (port_tracked(slot_tbl[id].lp, idx) && use_count[idx] != '0)
              use_count[idx] = use_count[idx] - 1'b1;
            r.status = ST_OK;
          end
        end
        OP_ALLOC: begin
          start = last_port;
          cur = step_port(start);
          r.status = ST_EXHAUSTED;
          for (int n = 0; n < 65537; n++) begin
            if (!port_tracked(cur, idx) || use_count[idx] == '0) begin
              last_port = cur;
              r.port = cur;
              r.status = ST_OK;
              break;
            end
            if (cur == start) break;
            cur = step_port(cur);
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t r;
    if (!rst_ni) begin
      expected_replies.delete();
      eph_first = FIRST_RST;
      eph_end = END_RST;
      empty_table();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FIRST) eph_first = cfg_data_i;
        else eph_end = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_replies.size() == 0) report("unexpected transaction", 1, 0);
        else begin
          r = expected_replies.pop_front();
          if (status_i != r.status) report("status", status_i, r.status);
          if (found_conn_i != r.found) report("found_conn", found_conn_i, r.found);
          if (match_level_i != r.level) report("match_level", match_level_i, r.level);
          if (port_i != r.port) report("port", port_i, r.port);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_table_op(r);
        expected_replies.push_back(r);
      end
    end
    pending_o = expected_replies.size();
  end

endmodule

// File: sim/connection_demux_table_with_ports_tb.sv
// Testbench top for the connection demux table: clock, reset, configuration phases,
// directed and random transactions with random idling. Depends on cdt_pkg,
// connection_demux_table_with_ports and conn_table_checker.
`timescale 1ns / 100ps
module connection_demux_table_with_ports_tb;
  import cdt_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_index_i = CFG_FIRST;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         operation_i = OP_LOOKUP;
  logic               clear_all_i = 1'b0;
  logic [5:0]         conn_id_i = '0;
  logic [31:0]        local_addr_i = '0;
  logic [31:0]        remote_addr_i = '0;
  logic [15:0]        local_port_i = '0;
  logic signed [16:0] remote_port_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic [5:0]         found_conn_o;
  logic [1:0]         match_level_o;
  logic [15:0]        port_o;
  int                 fail_count, pending;
  int                 send_idle_pct = 0, recv_stall_pct = 0;
  logic [15:0]        cur_first = FIRST_RST;

  localparam logic [31:0] ADDR_A = 32'h0a000001;
  localparam logic [31:0] ADDR_B = 32'h0a000002;
  localparam logic [31:0] ADDR_C = 32'h0a000003;
  localparam logic [16:0] ANY = RPORT_ANY;

  always #5 clk_i = ~clk_i;

  connection_demux_table_with_ports u_top (.*);

  conn_table_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .clear_all_i, .conn_id_i,
    .local_addr_i, .remote_addr_i, .local_port_i, .remote_port_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .found_conn_i(found_conn_o), .match_level_i(match_level_o), .port_i(port_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(negedge clk_i) out_stall_i = ($urandom_range(99) < recv_stall_pct);

  task automatic send(input op_e op, input logic clr, input logic [5:0] id,
                      input logic [31:0] la, input logic [31:0] ra,
                      input logic [15:0] lp, input logic [16:0] rp);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    operation_i = op;
    clear_all_i = clr;
    conn_id_i = id;
    local_addr_i = la;
    remote_addr_i = ra;
    local_port_i = lp;
    remote_port_i = rp;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(7))
      0, 1:    return '0;
      2, 3, 4: return ADDR_A + $urandom_range(2);
      5:       return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    int          r;
    op_e         op;
    logic [15:0] lp;
    logic [16:0] rp;
    r = $urandom_range(99);
    op = (r < 35) ? OP_LOOKUP : (r < 60) ? OP_INSERT : (r < 70) ? OP_UPDATE :
         (r < 85) ? OP_REMOVE : OP_ALLOC;
    r = $urandom_range(9);
    lp = (r < 6) ? cur_first + 16'($urandom_range(3)) :
         (r < 8) ? 16'(80 + $urandom_range(1)) : 16'($urandom);
    r = $urandom_range(9);
    rp = (r < 4) ? ANY : (r < 8) ? 17'(1000 + $urandom_range(3)) : 17'($urandom_range(65535));
    send(op, ($urandom_range(99) == 0), 6'($urandom), pick_addr(), pick_addr(), lp, rp);
  endtask

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [15:0] firsts[5];
    logic [15:0] ends[5];
    firsts = '{16'd1024, 16'd2000, 16'd0, 16'd65535, 16'd61440};
    ends   = '{16'd5000, 16'd2004, 16'd65535, 16'd1, 16'd65535};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    send_idle_pct = 28;
    recv_stall_pct = 46;

    send(OP_INSERT, 0, 0, ADDR_A, ADDR_B, 16'd1024, 17'd80);
    send(OP_INSERT, 0, 0, ADDR_C, ADDR_B, 16'd1024, 17'd81);
    send(OP_INSERT, 0, 1, ADDR_A, ADDR_B, 16'd1024, 17'd80);
    send(OP_INSERT, 0, 2, ADDR_A, '0, 16'd1024, ANY);
    send(OP_INSERT, 0, 3, ADDR_A, '0, 16'd1024, ANY);
    send(OP_INSERT, 0, 4, '0, '0, 16'd1024, ANY);
    send(OP_INSERT, 0, 5, '0, ADDR_B, 16'd1025, 17'd80);
    send(OP_LOOKUP, 0, 0, ADDR_A, ADDR_B, 16'd1024, 17'd80);
    send(OP_LOOKUP, 0, 0, ADDR_C, ADDR_B, 16'd1025, 17'd80);
    send(OP_LOOKUP, 0, 0, ADDR_A, ADDR_C, 16'd1024, 17'd7);
    send(OP_LOOKUP, 0, 0, ADDR_C, ADDR_C, 16'd1024, 17'd7);
    send(OP_LOOKUP, 0, 0, ADDR_C, ADDR_C, 16'd9, 17'd7);
    send(OP_UPDATE, 0, 0, ADDR_C, ADDR_C, 16'd1, 17'd90);
    send(OP_UPDATE, 0, 10, ADDR_C, ADDR_C, 16'd1, 17'd90);
    send(OP_REMOVE, 0, 0, '0, '0, '0, '0);
    send(OP_REMOVE, 0, 0, '0, '0, '0, '0);
    send(OP_ALLOC, 0, 0, '0, '0, '0, '0);
    send(OP_ALLOC, 0, 0, '0, '0, '0, '0);
    send(OP_INSERT, 0, 63, '1, '1, 16'hffff, 17'd65535);
    send(OP_LOOKUP, 0, 0, '1, '1, 16'hffff, 17'd65535);
    send(OP_REMOVE, 0, 63, '0, '0, '0, '0);
    send(OP_LOOKUP, 1, 0, '0, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 46;
        recv_stall_pct = 28;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_cfg(CFG_FIRST, firsts[ph]);
      write_cfg(CFG_END, ends[ph]);
      cur_first = firsts[ph];
      send(OP_LOOKUP, 1, 0, '0, '0, '0, '0);
      for (int i = 0; i < 4; i++)
        send(OP_INSERT, 0, 6'(i), ADDR_A, ADDR_B, cur_first + 16'(i), 17'(i));
      send(OP_ALLOC, 0, 0, '0, '0, '0, '0);
      repeat (350) send_random();
      drain();
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
